// ===== rtl/tpi_pkg.sv =====
package tpi_pkg;

    localparam int COORD_LIMIT_DEF = 33554431;

    localparam int CW   = 26;       // vertex coordinate
    localparam int EW   = 27;       // edge component
    localparam int NW   = 54;       // cross product component, signed
    localparam int MW   = 53;       // cross product magnitude
    localparam int LW   = 27;       // low half of a split magnitude
    localparam int HW   = MW - LW;  // high half of a split magnitude
    localparam int SQW  = 108;      // sum of squares
    localparam int RW   = SQW / 2;  // square root
    localparam int OW   = 25;       // normal output
    localparam int DW   = 26;       // offset output

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } t_vtx;

    typedef struct packed {
        logic signed [NW-1:0] x;
        logic signed [NW-1:0] y;
        logic signed [NW-1:0] z;
    } t_nrm;

    // what travels beside the arithmetic
    typedef struct packed {
        t_vtx a;
        t_nrm n;
        logic degen;
    } t_side;

endpackage

// ===== rtl/tpi_front.sv =====
module tpi_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  tpi_pkg::t_vtx   i_a,
    input  tpi_pkg::t_vtx   i_b,
    input  tpi_pkg::t_vtx   i_c,
    output logic            o_valid,
    output logic [tpi_pkg::SQW-1:0] o_sum,
    output tpi_pkg::t_side  o_side
);
    import tpi_pkg::*;

    logic [5:0] r_v;

    logic signed [EW-1:0] r_e1 [3];
    logic signed [EW-1:0] r_e2 [3];
    logic signed [NW-1:0] r_p [6];
    logic signed [NW-1:0] r_n3 [3];
    logic [2*HW-1:0]      r_hh [3];
    logic [HW+LW-1:0]     r_hl [3];
    logic [2*LW-1:0]      r_ll [3];
    logic [SQW-1:0]       r_sq [3];
    logic [SQW-1:0]       r_sum;
    t_vtx  r_a1, r_a2, r_a3, r_a4, r_a5, r_a6;
    t_nrm  r_n4, r_n5, r_n6;
    logic  r_dg;

    logic signed [NW-1:0] c_neg [3];
    logic [MW-1:0]        c_mag [3];
    t_nrm                 c_n3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    assign c_n3 = '{x: r_n3[0], y: r_n3[1], z: r_n3[2]};

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            c_neg[j] = -r_n3[j];
            c_mag[j] = r_n3[j][NW-1] ? c_neg[j][MW-1:0] : r_n3[j][MW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // edges from the first vertex
            r_e1[0] <= EW'(i_b.x) - EW'(i_a.x);
            r_e1[1] <= EW'(i_b.y) - EW'(i_a.y);
            r_e1[2] <= EW'(i_b.z) - EW'(i_a.z);
            r_e2[0] <= EW'(i_c.x) - EW'(i_a.x);
            r_e2[1] <= EW'(i_c.y) - EW'(i_a.y);
            r_e2[2] <= EW'(i_c.z) - EW'(i_a.z);
            r_a1    <= i_a;
            // cross product terms
            r_p[0]  <= r_e1[1] * r_e2[2];
            r_p[1]  <= r_e1[2] * r_e2[1];
            r_p[2]  <= r_e1[2] * r_e2[0];
            r_p[3]  <= r_e1[0] * r_e2[2];
            r_p[4]  <= r_e1[0] * r_e2[1];
            r_p[5]  <= r_e1[1] * r_e2[0];
            r_a2    <= r_a1;
            r_n3[0] <= r_p[0] - r_p[1];
            r_n3[1] <= r_p[2] - r_p[3];
            r_n3[2] <= r_p[4] - r_p[5];
            r_a3    <= r_a2;
            // squares split into half-width products
            for (int j = 0; j < 3; j++) begin
                r_hh[j] <= c_mag[j][MW-1:LW] * c_mag[j][MW-1:LW];
                r_hl[j] <= c_mag[j][MW-1:LW] * c_mag[j][LW-1:0];
                r_ll[j] <= c_mag[j][LW-1:0]  * c_mag[j][LW-1:0];
            end
            r_a4 <= r_a3;
            r_n4 <= c_n3;
            for (int j = 0; j < 3; j++) begin
                r_sq[j] <= (SQW'(r_hh[j]) << (2*LW)) + (SQW'(r_hl[j]) << (LW+1))
                         + SQW'(r_ll[j]);
            end
            r_a5  <= r_a4;
            r_n5  <= r_n4;
            r_sum <= r_sq[0] + r_sq[1] + r_sq[2];
            r_dg  <= (r_n5.x == '0) && (r_n5.y == '0) && (r_n5.z == '0);
            r_a6  <= r_a5;
            r_n6  <= r_n5;
        end
    end

    assign o_valid = r_v[5];
    assign o_sum   = r_sum;
    assign o_side  = '{a: r_a6, n: r_n6, degen: r_dg};

endmodule

// ===== rtl/tpi_sqrt.sv =====
module tpi_sqrt (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [tpi_pkg::SQW-1:0] i_sum,
    input  tpi_pkg::t_side  i_side,
    output logic            o_valid,
    output logic [tpi_pkg::RW-1:0] o_root,
    output tpi_pkg::t_side  o_side
);
    import tpi_pkg::*;

    // one root bit per stage, restoring
    logic [SQW-1:0] r_rad  [RW];
    logic [RW-1:0]  r_root [RW];
    logic [RW+1:0]  r_rem  [RW];
    t_side          r_side [RW];
    logic [RW-1:0]  r_v;

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic [SQW-1:0] c_rad;
        logic [RW-1:0]  c_root;
        logic [RW+1:0]  c_rem;
        t_side          c_side;
        logic           c_v;
        logic [RW+3:0]  c_t, c_trial, c_diff;
        logic           c_ge;
        logic [RW+1:0]  n_rem;

        if (k == 0) begin : g_first
            assign c_rad  = i_sum;
            assign c_root = '0;
            assign c_rem  = '0;
            assign c_side = i_side;
            assign c_v    = i_valid;
        end else begin : g_next
            assign c_rad  = r_rad[k-1];
            assign c_root = r_root[k-1];
            assign c_rem  = r_rem[k-1];
            assign c_side = r_side[k-1];
            assign c_v    = r_v[k-1];
        end

        assign c_t     = {c_rem, c_rad[SQW-1 -: 2]};
        assign c_trial = {2'b00, c_root, 2'b01};
        assign c_diff  = c_t - c_trial;
        assign c_ge    = c_t >= c_trial;
        assign n_rem   = c_ge ? c_diff[RW+1:0] : c_t[RW+1:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= c_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k]  <= c_rad << 2;
                r_root[k] <= {c_root[RW-2:0], c_ge};
                r_rem[k]  <= n_rem;
                r_side[k] <= c_side;
            end
        end
    end

    assign o_valid = r_v[RW-1];
    assign o_root  = r_root[RW-1];
    assign o_side  = r_side[RW-1];

endmodule

// ===== rtl/tpi_div.sv =====
module tpi_div #(
    parameter  int COORD_LIMIT = tpi_pkg::COORD_LIMIT_DEF,
    localparam int HALF        = COORD_LIMIT / 2,
    localparam int QW          = $clog2(HALF + 1)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [tpi_pkg::RW-1:0] i_root,
    input  tpi_pkg::t_side  i_side,
    output logic            o_valid,
    output logic [QW-1:0]   o_q [3],
    output tpi_pkg::t_side  o_side
);
    import tpi_pkg::*;

    localparam int NUMW = MW + QW;
    localparam logic [QW-1:0] HV = QW'(HALF);

    logic [HW+QW-1:0] r_ph [3];
    logic [LW+QW-1:0] r_pl [3];
    logic [NUMW-1:0]  r_num [3];
    logic [RW-1:0]    r_rt0, r_rt1;
    t_side            r_sd0, r_sd1;
    logic [1:0]       r_vp;

    logic [RW-1:0] r_rem  [QW][3];
    logic [QW-1:0] r_low  [QW][3];
    logic [QW-1:0] r_q    [QW][3];
    logic [RW-1:0] r_root [QW];
    t_side         r_side [QW];
    logic [QW-1:0] r_v;

    logic signed [NW-1:0] c_n   [3];
    logic signed [NW-1:0] c_neg [3];
    logic [MW-1:0]        c_mag [3];

    assign c_n[0] = i_side.n.x;
    assign c_n[1] = i_side.n.y;
    assign c_n[2] = i_side.n.z;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            c_neg[j] = -c_n[j];
            c_mag[j] = c_n[j][NW-1] ? c_neg[j][MW-1:0] : c_n[j][MW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp <= '0;
        end else if (i_en) begin
            r_vp <= {r_vp[0], i_valid};
        end
    end

    // numerator |n| * floor(limit/2) from two half-width products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 3; j++) begin
                r_ph[j]  <= c_mag[j][MW-1:LW] * HV;
                r_pl[j]  <= c_mag[j][LW-1:0]  * HV;
                r_num[j] <= (NUMW'(r_ph[j]) << LW) + NUMW'(r_pl[j]);
            end
            r_rt0 <= i_root;
            r_sd0 <= i_side;
            r_rt1 <= r_rt0;
            r_sd1 <= r_sd0;
        end
    end

    // quotient never reaches 2^QW, so the top of the numerator starts below the root
    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [RW-1:0] c_rem [3];
        logic [QW-1:0] c_low [3];
        logic [QW-1:0] c_q   [3];
        logic [RW-1:0] c_root;
        t_side         c_side;
        logic          c_v;
        logic [RW:0]   c_t    [3];
        logic [RW:0]   c_diff [3];
        logic          c_ge   [3];

        if (k == 0) begin : g_first
            for (genvar j = 0; j < 3; j++) begin : g_lane
                assign c_rem[j] = RW'(r_num[j][NUMW-1:QW]);
                assign c_low[j] = r_num[j][QW-1:0];
                assign c_q[j]   = '0;
            end
            assign c_root = r_rt1;
            assign c_side = r_sd1;
            assign c_v    = r_vp[1];
        end else begin : g_next
            for (genvar j = 0; j < 3; j++) begin : g_lane
                assign c_rem[j] = r_rem[k-1][j];
                assign c_low[j] = r_low[k-1][j];
                assign c_q[j]   = r_q[k-1][j];
            end
            assign c_root = r_root[k-1];
            assign c_side = r_side[k-1];
            assign c_v    = r_v[k-1];
        end

        always_comb begin
            for (int j = 0; j < 3; j++) begin
                c_t[j]    = {c_rem[j], c_low[j][QW-1]};
                c_diff[j] = c_t[j] - {1'b0, c_root};
                c_ge[j]   = c_t[j] >= {1'b0, c_root};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= c_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int j = 0; j < 3; j++) begin
                    r_rem[k][j] <= c_ge[j] ? c_diff[j][RW-1:0] : c_t[j][RW-1:0];
                    r_low[k][j] <= c_low[j] << 1;
                    r_q[k][j]   <= {c_q[j][QW-2:0], c_ge[j]};
                end
                r_root[k] <= c_root;
                r_side[k] <= c_side;
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_q[0]  = r_q[QW-1][0];
    assign o_q[1]  = r_q[QW-1][1];
    assign o_q[2]  = r_q[QW-1][2];
    assign o_side  = r_side[QW-1];

endmodule

// ===== rtl/triangle_plane_integer.sv =====
// Triangle plane engine.
// Input channel: i_valid / o_ready carries one triangle request, three
// vertices of 26-bit signed coordinates (i_a_*, i_b_*, i_c_*).
// Output channel: o_valid / i_ready carries the plane: scaled unit normal
// (o_normal_*), offset (o_offset_d) and o_degenerate for a zero cross product,
// in which case every other field is zero.
// Throughput: one request per cycle while the output is not stalled. The
// square root takes one root bit per stage (54 stages) and the three
// dividers one quotient bit per stage (QW stages, QW = bits of
// floor(limit/2)).
// Front end: 6 stages (edges, products, cross, split squares, squares, sum).
// Back end: 3 stages (sign, dot product terms, sum and clamp).
// Stall: the whole pipeline advances as one; when the output holds a result
// that is not taken, every stage freezes and o_ready drops, so nothing is lost.
// Reset: synchronous, clears all stage valid bits; payload is not reset.
module triangle_plane_integer #(
    parameter int COORD_LIMIT = tpi_pkg::COORD_LIMIT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [tpi_pkg::CW-1:0] i_a_x,
    input  logic signed [tpi_pkg::CW-1:0] i_a_y,
    input  logic signed [tpi_pkg::CW-1:0] i_a_z,
    input  logic signed [tpi_pkg::CW-1:0] i_b_x,
    input  logic signed [tpi_pkg::CW-1:0] i_b_y,
    input  logic signed [tpi_pkg::CW-1:0] i_b_z,
    input  logic signed [tpi_pkg::CW-1:0] i_c_x,
    input  logic signed [tpi_pkg::CW-1:0] i_c_y,
    input  logic signed [tpi_pkg::CW-1:0] i_c_z,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [tpi_pkg::OW-1:0] o_normal_x,
    output logic signed [tpi_pkg::OW-1:0] o_normal_y,
    output logic signed [tpi_pkg::OW-1:0] o_normal_z,
    output logic signed [tpi_pkg::DW-1:0] o_offset_d,
    output logic                          o_degenerate
);
    import tpi_pkg::*;

    localparam int HALF = COORD_LIMIT / 2;
    localparam int QW   = $clog2(HALF + 1);
    localparam int SW   = QW + 1;        // signed scaled component
    localparam int PW   = SW + CW;       // dot product term
    localparam int SUMW = PW + 2;
    localparam logic signed [SUMW:0] LIM_S = (SUMW+1)'(COORD_LIMIT);

    // global advance: output empty or being taken
    logic en;
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    t_vtx a_in, b_in, c_in;
    assign a_in = '{x: i_a_x, y: i_a_y, z: i_a_z};
    assign b_in = '{x: i_b_x, y: i_b_y, z: i_b_z};
    assign c_in = '{x: i_c_x, y: i_c_y, z: i_c_z};

    logic           f_valid;
    logic [SQW-1:0] f_sum;
    t_side          f_side;

    tpi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_a     (a_in),
        .i_b     (b_in),
        .i_c     (c_in),
        .o_valid (f_valid),
        .o_sum   (f_sum),
        .o_side  (f_side)
    );

    logic          s_valid;
    logic [RW-1:0] s_root;
    t_side         s_side;

    tpi_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_sum   (f_sum),
        .i_side  (f_side),
        .o_valid (s_valid),
        .o_root  (s_root),
        .o_side  (s_side)
    );

    logic          d_valid;
    logic [QW-1:0] d_q [3];
    t_side         d_side;

    tpi_div #(
        .COORD_LIMIT (COORD_LIMIT)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_valid),
        .i_root  (s_root),
        .i_side  (s_side),
        .o_valid (d_valid),
        .o_q     (d_q),
        .o_side  (d_side)
    );

    // back end registers
    logic [2:0]           r_v;
    logic signed [SW-1:0] r_s1 [3];
    logic signed [SW-1:0] r_s2 [3];
    logic signed [PW-1:0] r_p2 [3];
    t_vtx                 r_a1;
    logic                 r_dg1, r_dg2;
    logic signed [OW-1:0] r_nx, r_ny, r_nz;
    logic signed [DW-1:0] r_d;
    logic                 r_dg;

    logic                 c_neg [3];
    logic signed [SW-1:0] c_pos [3];
    logic signed [SW-1:0] c_mns [3];
    logic signed [31:0]   c_wide [3];
    logic signed [SUMW-1:0] c_sum;
    logic signed [SUMW:0]   c_nd, c_cl;

    assign c_neg[0] = d_side.n.x[NW-1];
    assign c_neg[1] = d_side.n.y[NW-1];
    assign c_neg[2] = d_side.n.z[NW-1];

    // quotient never exceeds floor(limit/2), so the components need no clamp
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            c_pos[j]  = $signed({1'b0, d_q[j]});
            c_mns[j]  = -c_pos[j];
            c_wide[j] = 32'(r_s2[j]);
        end
    end

    assign c_sum = SUMW'(r_p2[0]) + SUMW'(r_p2[1]) + SUMW'(r_p2[2]);
    assign c_nd  = -((SUMW+1)'(c_sum));

    always_comb begin
        if (c_nd > LIM_S) begin
            c_cl = LIM_S;
        end else if (c_nd < -LIM_S) begin
            c_cl = -LIM_S;
        end else begin
            c_cl = c_nd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[1:0], d_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // restore sign
            for (int j = 0; j < 3; j++) begin
                r_s1[j] <= c_neg[j] ? c_mns[j] : c_pos[j];
            end
            r_a1  <= d_side.a;
            r_dg1 <= d_side.degen;
            // dot product terms against the first vertex
            r_p2[0] <= r_s1[0] * r_a1.x;
            r_p2[1] <= r_s1[1] * r_a1.y;
            r_p2[2] <= r_s1[2] * r_a1.z;
            r_s2    <= r_s1;
            r_dg2   <= r_dg1;
            // output register
            r_nx <= r_dg2 ? '0 : c_wide[0][OW-1:0];
            r_ny <= r_dg2 ? '0 : c_wide[1][OW-1:0];
            r_nz <= r_dg2 ? '0 : c_wide[2][OW-1:0];
            r_d  <= r_dg2 ? '0 : c_cl[DW-1:0];
            r_dg <= r_dg2;
        end
    end

    assign o_valid      = r_v[2];
    assign o_normal_x   = r_nx;
    assign o_normal_y   = r_ny;
    assign o_normal_z   = r_nz;
    assign o_offset_d   = r_d;
    assign o_degenerate = r_dg;

endmodule
